### rtl/core/slt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// slt_pkg
// shared types, token kinds and scanner mode codes for the tokenizer
// ---------------------------------------------------------------------------
package slt_pkg;

    // token kinds
    localparam logic [4:0] K_ID     = 5'd0;
    localparam logic [4:0] K_RET    = 5'd1;
    localparam logic [4:0] K_INT    = 5'd2;
    localparam logic [4:0] K_STR    = 5'd3;
    localparam logic [4:0] K_EQ     = 5'd4;
    localparam logic [4:0] K_ARROW  = 5'd5;
    localparam logic [4:0] K_LPAR   = 5'd6;
    localparam logic [4:0] K_RPAR   = 5'd7;
    localparam logic [4:0] K_LBRACE = 5'd8;
    localparam logic [4:0] K_RBRACE = 5'd9;
    localparam logic [4:0] K_LBRACK = 5'd10;
    localparam logic [4:0] K_RBRACK = 5'd11;
    localparam logic [4:0] K_COLON  = 5'd12;
    localparam logic [4:0] K_COMMA  = 5'd13;
    localparam logic [4:0] K_LT     = 5'd14;
    localparam logic [4:0] K_GT     = 5'd15;
    localparam logic [4:0] K_SEMI   = 5'd16;
    localparam logic [4:0] K_PLUS   = 5'd17;
    localparam logic [4:0] K_MINUS  = 5'd18;
    localparam logic [4:0] K_DIV    = 5'd19;
    localparam logic [4:0] K_MUL    = 5'd20;
    localparam logic [4:0] K_EOF    = 5'd21;
    localparam logic [4:0] K_ERR    = 5'd22;

    // scanner modes
    localparam logic [3:0] M_IDLE  = 4'd0;
    localparam logic [3:0] M_ID    = 4'd1;
    localparam logic [3:0] M_INT   = 4'd2;
    localparam logic [3:0] M_STR   = 4'd3;
    localparam logic [3:0] M_EQ    = 4'd4;
    localparam logic [3:0] M_SLASH = 4'd5;
    localparam logic [3:0] M_LINE  = 4'd6;
    localparam logic [3:0] M_BLOCK = 4'd7;
    localparam logic [3:0] M_BSTAR = 4'd8;

    // characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;

    // keyword "return"
    localparam logic [2:0] KW_LEN = 3'd6;

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] ch;
        logic       has;
        logic       first;
        logic       tok_end;
        logic       last;
    } t_token;

    typedef struct packed {
        logic [1:0] cnt;
        t_token     r0;
        t_token     r1;
    } t_scan_res;

    function automatic logic is_letter(input logic [7:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h72; // r
            3'd1:    c = 8'h65; // e
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h75; // u
            3'd4:    c = 8'h72; // r
            3'd5:    c = 8'h6E; // n
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/core/slt_scan.sv
`default_nettype none
// ---------------------------------------------------------------------------
// slt_scan
// scanner state and per-byte classification, up to two tokens per byte
// ---------------------------------------------------------------------------
module slt_scan (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire logic [7:0]        i_byte,
    output slt_pkg::t_scan_res     o_res
);
    import slt_pkg::*;

    typedef struct packed {
        logic [3:0] mode;
        logic       emit;
        t_token     res;
        logic       halt;
        logic       id_start;
    } t_idle;

    function automatic t_token mk_tok(input logic [4:0] kind, input logic [7:0] ch,
                                      input logic has, input logic first,
                                      input logic tok_end);
        t_token t;
        t.kind    = kind;
        t.ch      = ch;
        t.has     = has;
        t.first   = first;
        t.tok_end = tok_end;
        t.last    = 1'b0;
        return t;
    endfunction

    // classification of a byte seen between tokens
    function automatic t_idle scan_idle(input logic [7:0] b);
        t_idle s;
        s.mode     = M_IDLE;
        s.emit     = 1'b0;
        s.res      = mk_tok(K_ERR, b, 1'b1, 1'b1, 1'b1);
        s.halt     = 1'b0;
        s.id_start = 1'b0;
        if (b == CH_NUL) begin
            s.emit = 1'b1;
            s.res  = mk_tok(K_EOF, CH_NUL, 1'b0, 1'b1, 1'b1);
        end else if (b inside {CH_CR, CH_LF, CH_SPACE, CH_TAB}) begin
            s.emit = 1'b0;
        end else if (is_letter(b)) begin
            s.mode     = M_ID;
            s.id_start = 1'b1;
            s.emit     = 1'b1;
            s.res      = mk_tok(K_ID, b, 1'b1, 1'b1, 1'b0);
        end else if (is_digit(b)) begin
            s.mode = M_INT;
            s.emit = 1'b1;
            s.res  = mk_tok(K_INT, b, 1'b1, 1'b1, 1'b0);
        end else if (b == CH_QUOTE) begin
            s.mode = M_STR;
            s.emit = 1'b1;
            s.res  = mk_tok(K_STR, CH_NUL, 1'b0, 1'b1, 1'b0);
        end else if (b == CH_EQ) begin
            s.mode = M_EQ;
        end else if (b == CH_SLASH) begin
            s.mode = M_SLASH;
        end else begin
            s.emit = 1'b1;
            case (b)
                8'h28:   s.res.kind = K_LPAR;
                8'h29:   s.res.kind = K_RPAR;
                8'h7B:   s.res.kind = K_LBRACE;
                8'h7D:   s.res.kind = K_RBRACE;
                8'h5B:   s.res.kind = K_LBRACK;
                8'h5D:   s.res.kind = K_RBRACK;
                8'h3A:   s.res.kind = K_COLON;
                8'h2C:   s.res.kind = K_COMMA;
                8'h3C:   s.res.kind = K_LT;
                8'h3E:   s.res.kind = K_GT;
                8'h3B:   s.res.kind = K_SEMI;
                8'h2B:   s.res.kind = K_PLUS;
                8'h2D:   s.res.kind = K_MINUS;
                8'h2A:   s.res.kind = K_MUL;
                default: s.halt     = 1'b1;
            endcase
        end
        return s;
    endfunction

    logic [3:0] r_mode, n_mode;
    logic [2:0] r_prog, n_prog;
    logic       r_miss, n_miss;
    logic       r_halted, n_halted;

    t_idle  idl;
    logic   pre_v;
    t_token pre;
    logic   do_idle;
    logic   emit_idle;

    always_comb begin
        n_mode   = r_mode;
        n_prog   = r_prog;
        n_miss   = r_miss;
        n_halted = r_halted;
        pre_v    = 1'b0;
        pre      = mk_tok(K_ID, CH_NUL, 1'b0, 1'b0, 1'b0);
        do_idle  = 1'b0;
        idl      = scan_idle(i_byte);

        if (!r_halted) begin
            case (r_mode)
                M_ID: begin
                    pre_v = 1'b1;
                    if (is_letter(i_byte)) begin
                        pre = mk_tok(K_ID, i_byte, 1'b1, 1'b0, 1'b0);
                        if (!r_miss) begin
                            if (r_prog < KW_LEN && i_byte == kw_char(r_prog)) begin
                                n_prog = r_prog + 3'd1;
                            end else begin
                                n_miss = 1'b1;
                            end
                        end
                    end else begin
                        pre = mk_tok((r_prog == KW_LEN && !r_miss) ? K_RET : K_ID,
                                     CH_NUL, 1'b0, 1'b0, 1'b1);
                        do_idle = 1'b1;
                    end
                end
                M_INT: begin
                    pre_v = 1'b1;
                    if (is_digit(i_byte)) begin
                        pre = mk_tok(K_INT, i_byte, 1'b1, 1'b0, 1'b0);
                    end else begin
                        pre     = mk_tok(K_INT, CH_NUL, 1'b0, 1'b0, 1'b1);
                        do_idle = 1'b1;
                    end
                end
                M_STR: begin
                    pre_v = 1'b1;
                    if (i_byte == CH_QUOTE) begin
                        pre    = mk_tok(K_STR, CH_NUL, 1'b0, 1'b0, 1'b1);
                        n_mode = M_IDLE;
                    end else if (i_byte == CH_NUL) begin
                        pre     = mk_tok(K_STR, CH_NUL, 1'b0, 1'b0, 1'b1);
                        do_idle = 1'b1;
                    end else begin
                        pre = mk_tok(K_STR, i_byte, 1'b1, 1'b0, 1'b0);
                    end
                end
                M_EQ: begin
                    pre_v = 1'b1;
                    if (i_byte == CH_GT) begin
                        pre    = mk_tok(K_ARROW, CH_NUL, 1'b0, 1'b1, 1'b1);
                        n_mode = M_IDLE;
                    end else begin
                        pre     = mk_tok(K_EQ, CH_EQ, 1'b1, 1'b1, 1'b1);
                        do_idle = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (i_byte == CH_SLASH) begin
                        n_mode = M_LINE;
                    end else if (i_byte == CH_STAR) begin
                        n_mode = M_BLOCK;
                    end else begin
                        pre_v   = 1'b1;
                        pre     = mk_tok(K_DIV, CH_SLASH, 1'b1, 1'b1, 1'b1);
                        do_idle = 1'b1;
                    end
                end
                M_LINE: begin
                    if (i_byte == CH_LF) begin
                        n_mode = M_IDLE;
                    end else if (i_byte == CH_NUL) begin
                        do_idle = 1'b1;
                    end
                end
                M_BLOCK: begin
                    if (i_byte == CH_STAR) begin
                        n_mode = M_BSTAR;
                    end else if (i_byte == CH_NUL) begin
                        do_idle = 1'b1;
                    end
                end
                M_BSTAR: begin
                    if (i_byte == CH_SLASH) begin
                        n_mode = M_IDLE;
                    end else if (i_byte == CH_NUL) begin
                        do_idle = 1'b1;
                    end else if (i_byte != CH_STAR) begin
                        n_mode = M_BLOCK;
                    end
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase
        end

        if (do_idle) begin
            n_mode = idl.mode;
            if (idl.id_start) begin
                n_prog = (i_byte == kw_char(3'd0)) ? 3'd1 : 3'd0;
                n_miss = (i_byte != kw_char(3'd0));
            end
            if (idl.halt) begin
                n_halted = 1'b1;
            end
        end

        emit_idle = do_idle && idl.emit;
        o_res.cnt = {1'b0, pre_v} + {1'b0, emit_idle};
        o_res.r0  = pre_v ? pre : idl.res;
        o_res.r1  = idl.res;
        if (pre_v && emit_idle) begin
            o_res.r0.last = 1'b0;
            o_res.r1.last = 1'b1;
        end else begin
            o_res.r0.last = 1'b1;
            o_res.r1.last = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_prog   <= 3'd0;
            r_miss   <= 1'b0;
            r_halted <= 1'b0;
        end else if (i_advance) begin
            r_mode   <= n_mode;
            r_prog   <= n_prog;
            r_miss   <= n_miss;
            r_halted <= n_halted;
        end
    end

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> o_res.cnt == 2'd0)
        else $error("halted scanner produced a token");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt cleared without reset");

    a_prog_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prog <= KW_LEN)
        else $error("keyword progress past end of word");

endmodule
`default_nettype wire

### rtl/core/slt_obuf.sv
`default_nettype none
// ---------------------------------------------------------------------------
// slt_obuf
// output register plus one hold slot for the second token of a byte
// ---------------------------------------------------------------------------
module slt_obuf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire slt_pkg::t_scan_res i_res,
    output logic                   o_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output slt_pkg::t_token        o_tok
);
    import slt_pkg::*;

    logic   r_out_vld;
    t_token r_out;
    logic   r_hold_vld;
    t_token r_hold;
    logic   out_free;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_ready     = out_free && !r_hold_vld;
    assign o_out_valid = r_out_vld;
    assign o_tok       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
        end else if (out_free) begin
            if (r_hold_vld) begin
                r_out_vld  <= 1'b1;
                r_hold_vld <= 1'b0;
            end else if (i_load && i_res.cnt != 2'd0) begin
                r_out_vld  <= 1'b1;
                r_hold_vld <= (i_res.cnt == 2'd2);
            end else begin
                r_out_vld  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_hold_vld) begin
                r_out <= r_hold;
            end else if (i_load && i_res.cnt != 2'd0) begin
                r_out  <= i_res.r0;
                r_hold <= i_res.r1;
            end
        end
    end

    a_hold_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_vld |-> r_out_vld)
        else $error("hold slot filled while output empty");

    a_pair_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && o_ready && i_res.cnt == 2'd2) |=> (r_hold_vld && !r_out.last))
        else $error("second token of a pair not held");

    a_no_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_ready)
        else $error("scanner advanced while output buffer busy");

endmodule
`default_nettype wire

### rtl/core/small_language_tokenizer_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// small_language_tokenizer_top
// streaming tokenizer, one source byte per request in, token events out
// ---------------------------------------------------------------------------
// Takes one source byte per request and emits token events. Whitespace and
// both comment styles are skipped; identifiers, integers and strings come out
// one event per character between a first and a closing event, and "return"
// is marked as a keyword on the closing event. Byte 0 closes any open token
// and gives EOF, after which a new source may follow. An unexpected byte gives
// an error event and the block goes silent (bytes are still taken) until
// reset. Rate: one byte per cycle, held off by output stalls and held events;
// an event is registered at the output in the cycle after its byte leaves the
// input register. A byte with two events (a token closed by the byte that
// starts the next one) keeps the second in a hold slot while the input stalls.
// ---------------------------------------------------------------------------
module small_language_tokenizer_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_source_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [4:0]      o_token_kind,
    output logic [7:0]      o_value_char,
    output logic            o_has_char,
    output logic            o_token_first,
    output logic            o_token_end,
    output logic            o_run_last
);
    import slt_pkg::*;

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;

    logic       accept;
    logic       advance;
    logic       buf_ready;
    t_scan_res  scan_res;
    t_token     out_tok;

    // the scanner consumes the registered byte whenever the output side
    // can take both of its possible events
    assign advance    = r_in_vld && buf_ready;
    assign o_in_stall = r_in_vld && !buf_ready;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_source_byte;
        end
    end

    slt_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_res     (scan_res)
    );

    slt_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_res       (scan_res),
        .o_ready     (buf_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_tok       (out_tok)
    );

    // unpack the output token onto the ports
    assign o_token_kind  = out_tok.kind;
    assign o_value_char  = out_tok.ch;
    assign o_has_char    = out_tok.has;
    assign o_token_first = out_tok.first;
    assign o_token_end   = out_tok.tok_end;
    assign o_run_last    = out_tok.last;

endmodule
`default_nettype wire

### dv/tb_small_language_tokenizer_top.sv
// ---------------------------------------------------------------------------
// tb_small_language_tokenizer_top
// self-checking bench for the streaming tokenizer
// ---------------------------------------------------------------------------
// The bench plays a short table of hand-picked source bytes first. Some rows
// carry their token events written out; the rest are checked by the scanner
// model. Then about 1500 bytes of random source follow, built mostly from
// well-formed lexemes with random content. Every accepted byte runs through
// the scanner model kept here. The events it produces are queued and compared
// field by field with what the block emits. Both handshakes idle in random
// bursts. The run closes with an unexpected byte, after which the block must
// stay silent.
// ---------------------------------------------------------------------------
module tb_small_language_tokenizer_top;
    import slt_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RAND_BYTES   = 1500;
    localparam int CALM_TAIL    = 200;     // last random bytes with no idling
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 500000;

    localparam logic [47:0]  RET_WORD  = "return";
    localparam logic [119:0] PUNCT_SET = "(){}[]:,<>;+-/*";
    localparam t_token       NO_EV     = '0;

    // scanner state as the bench tracks it
    typedef struct packed {
        logic [3:0] mode;
        logic [2:0] kw_hits;      // letters of the keyword matched so far
        logic       kw_broken;    // identifier can no longer be the keyword
        logic       halted;
    } lexer_state_t;

    // one row of the directed table; typed rows carry their events
    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        t_scan_res  want;
    } source_row_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_source_byte = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [4:0] o_token_kind;
    logic [7:0] o_value_char;
    logic       o_has_char;
    logic       o_token_first;
    logic       o_token_end;
    logic       o_run_last;

    lexer_state_t lex_st;
    t_token       token_q[$];     // token events still owed by the block
    logic [7:0]   lexeme_q[$];    // random source waiting to be sent
    source_row_t  src_rows[$];
    int unsigned  fail_cnt = 0;
    bit           steady_tail = 1'b0;
    bit           in_calm = 1'b0;
    bit           out_calm = 1'b0;
    int unsigned  out_hold = 0;

    small_language_tokenizer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_source_byte (i_source_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_token_kind  (o_token_kind),
        .o_value_char  (o_value_char),
        .o_has_char    (o_has_char),
        .o_token_first (o_token_first),
        .o_token_end   (o_token_end),
        .o_run_last    (o_run_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // scanner model
    // -----------------------------------------------------------------------
    function automatic logic alpha_byte(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic logic digit_byte(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic t_token tk(input logic [4:0] kind, input logic [7:0] ch,
                                  input logic has, input logic first,
                                  input logic fin, input logic last);
        t_token t;
        t.kind    = kind;
        t.ch      = ch;
        t.has     = has;
        t.first   = first;
        t.tok_end = fin;
        t.last    = last;
        return t;
    endfunction

    // at most two events per byte
    function automatic void add_event(inout t_scan_res r, input t_token t);
        if (r.cnt == 2'd0)
            r.r0 = t;
        else if (r.cnt == 2'd1)
            r.r1 = t;
        if (r.cnt < 2'd2)
            r.cnt = r.cnt + 2'd1;
    endfunction

    function automatic void track_keyword(inout lexer_state_t st, input logic [7:0] b);
        if (!st.kw_broken) begin
            if (st.kw_hits < KW_LEN && b == RET_WORD[8 * (5 - st.kw_hits) +: 8])
                st.kw_hits = st.kw_hits + 3'd1;
            else
                st.kw_broken = 1'b1;
        end
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] b, output logic hit);
        logic [4:0] k;
        hit = 1'b1;
        k   = K_ERR;
        case (b)
            "(":     k = K_LPAR;
            ")":     k = K_RPAR;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            ":":     k = K_COLON;
            ",":     k = K_COMMA;
            "<":     k = K_LT;
            ">":     k = K_GT;
            ";":     k = K_SEMI;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "/":     k = K_DIV;
            "*":     k = K_MUL;
            default: hit = 1'b0;
        endcase
        return k;
    endfunction

    // byte seen between tokens
    function automatic void lex_idle(inout lexer_state_t st, inout t_scan_res r,
                                     input logic [7:0] b);
        logic       hit;
        logic [4:0] k;
        st.mode = M_IDLE;
        if (b == CH_NUL) begin
            add_event(r, tk(K_EOF, CH_NUL, 1'b0, 1'b1, 1'b1, 1'b0));
        end else if (b == CH_CR || b == CH_LF || b == CH_SPACE || b == CH_TAB) begin
            // whitespace is dropped
        end else if (alpha_byte(b)) begin
            st.mode      = M_ID;
            st.kw_hits   = '0;
            st.kw_broken = 1'b0;
            track_keyword(st, b);
            add_event(r, tk(K_ID, b, 1'b1, 1'b1, 1'b0, 1'b0));
        end else if (digit_byte(b)) begin
            st.mode = M_INT;
            add_event(r, tk(K_INT, b, 1'b1, 1'b1, 1'b0, 1'b0));
        end else if (b == CH_QUOTE) begin
            st.mode = M_STR;
            add_event(r, tk(K_STR, CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0));
        end else if (b == CH_EQ) begin
            st.mode = M_EQ;
        end else if (b == CH_SLASH) begin
            st.mode = M_SLASH;
        end else begin
            k = punct_kind(b, hit);
            if (hit) begin
                add_event(r, tk(k, b, 1'b1, 1'b1, 1'b1, 1'b0));
            end else begin
                add_event(r, tk(K_ERR, b, 1'b1, 1'b1, 1'b1, 1'b0));
                st.halted = 1'b1;
            end
        end
    endfunction

    function automatic t_scan_res lex_step(inout lexer_state_t st, input logic [7:0] b);
        t_scan_res r;
        r = '0;
        if (!st.halted) begin
            case (st.mode)
                M_ID: begin
                    if (alpha_byte(b)) begin
                        track_keyword(st, b);
                        add_event(r, tk(K_ID, b, 1'b1, 1'b0, 1'b0, 1'b0));
                    end else begin
                        add_event(r, tk((st.kw_hits == KW_LEN && !st.kw_broken) ? K_RET : K_ID,
                                        CH_NUL, 1'b0, 1'b0, 1'b1, 1'b0));
                        lex_idle(st, r, b);
                    end
                end
                M_INT: begin
                    if (digit_byte(b)) begin
                        add_event(r, tk(K_INT, b, 1'b1, 1'b0, 1'b0, 1'b0));
                    end else begin
                        add_event(r, tk(K_INT, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b0));
                        lex_idle(st, r, b);
                    end
                end
                M_STR: begin
                    if (b == CH_QUOTE) begin
                        add_event(r, tk(K_STR, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b0));
                        st.mode = M_IDLE;
                    end else if (b == CH_NUL) begin
                        add_event(r, tk(K_STR, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b0));
                        lex_idle(st, r, b);
                    end else begin
                        add_event(r, tk(K_STR, b, 1'b1, 1'b0, 1'b0, 1'b0));
                    end
                end
                M_EQ: begin
                    if (b == CH_GT) begin
                        add_event(r, tk(K_ARROW, CH_NUL, 1'b0, 1'b1, 1'b1, 1'b0));
                        st.mode = M_IDLE;
                    end else begin
                        add_event(r, tk(K_EQ, CH_EQ, 1'b1, 1'b1, 1'b1, 1'b0));
                        lex_idle(st, r, b);
                    end
                end
                M_SLASH: begin
                    if (b == CH_SLASH) begin
                        st.mode = M_LINE;
                    end else if (b == CH_STAR) begin
                        st.mode = M_BLOCK;
                    end else begin
                        add_event(r, tk(K_DIV, CH_SLASH, 1'b1, 1'b1, 1'b1, 1'b0));
                        lex_idle(st, r, b);
                    end
                end
                M_LINE: begin
                    if (b == CH_LF)
                        st.mode = M_IDLE;
                    else if (b == CH_NUL)
                        lex_idle(st, r, b);
                end
                M_BLOCK: begin
                    if (b == CH_STAR)
                        st.mode = M_BSTAR;
                    else if (b == CH_NUL)
                        lex_idle(st, r, b);
                end
                M_BSTAR: begin
                    if (b == CH_SLASH)
                        st.mode = M_IDLE;
                    else if (b == CH_NUL)
                        lex_idle(st, r, b);
                    else if (b != CH_STAR)
                        st.mode = M_BLOCK;
                end
                default: lex_idle(st, r, b);
            endcase
            // last event of this byte
            if (r.cnt == 2'd1)
                r.r0.last = 1'b1;
            else if (r.cnt == 2'd2)
                r.r1.last = 1'b1;
        end
        return r;
    endfunction

    // would this byte halt the scanner in its present state
    function automatic logic halts_scanner(input logic [7:0] b);
        lexer_state_t probe;
        probe = lex_st;
        void'(lex_step(probe, b));
        return probe.halted;
    endfunction

    function automatic void queue_events(input t_scan_res r);
        if (r.cnt >= 2'd1)
            token_q.push_back(r.r0);
        if (r.cnt == 2'd2)
            token_q.push_back(r.r1);
    endfunction

    // -----------------------------------------------------------------------
    // source generation
    // -----------------------------------------------------------------------
    function automatic source_row_t row_model(input logic [7:0] b);
        source_row_t s;
        s   = '0;
        s.b = b;
        return s;
    endfunction

    function automatic source_row_t row_fixed(input logic [7:0] b, input logic [1:0] n,
                                              input t_token e0, input t_token e1);
        source_row_t s;
        s.b       = b;
        s.typed   = 1'b1;
        s.want.cnt = n;
        s.want.r0 = e0;
        s.want.r1 = e1;
        return s;
    endfunction

    // one lexeme with random content, sometimes followed by whitespace
    function automatic void build_lexeme();
        int unsigned pick;
        int unsigned n;
        int unsigned kw_len;
        int unsigned l;
        logic [7:0]  c;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            // identifiers, with the keyword, its prefixes and longer words
            case ($urandom_range(0, 3))
                0: begin
                    kw_len = 6;
                    n      = 0;
                end
                1: begin
                    kw_len = $urandom_range(1, 5);
                    n      = $urandom_range(0, 2);
                end
                2: begin
                    kw_len = 6;
                    n      = $urandom_range(1, 3);
                end
                default: begin
                    kw_len = 0;
                    n      = $urandom_range(1, 8);
                end
            endcase
            for (int i = 0; i < kw_len; i++)
                lexeme_q.push_back(RET_WORD[8 * (5 - i) +: 8]);
            repeat (n) begin
                l = $urandom_range(0, 51);
                lexeme_q.push_back((l < 26) ? 8'("A" + l) : 8'("a" + l - 26));
            end
        end else if (pick < 36) begin
            repeat ($urandom_range(1, 6))
                lexeme_q.push_back(8'("0" + $urandom_range(0, 9)));
        end else if (pick < 50) begin
            // string with any content byte, sometimes cut off by end of source
            lexeme_q.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 8)) begin
                c = 8'($urandom_range(1, 255));
                lexeme_q.push_back(c == CH_QUOTE ? CH_SPACE : c);
            end
            lexeme_q.push_back($urandom_range(0, 7) == 0 ? CH_NUL : CH_QUOTE);
        end else if (pick < 58) begin
            lexeme_q.push_back(CH_EQ);
            if ($urandom_range(0, 1) == 0)
                lexeme_q.push_back(CH_GT);
        end else if (pick < 76) begin
            n = $urandom_range(0, 14);
            lexeme_q.push_back(PUNCT_SET[8 * (14 - n) +: 8]);
        end else if (pick < 84) begin
            lexeme_q.push_back(CH_SLASH);
            lexeme_q.push_back(CH_SLASH);
            repeat ($urandom_range(0, 10)) begin
                c = 8'($urandom_range(1, 255));
                lexeme_q.push_back(c == CH_LF ? CH_SPACE : c);
            end
            lexeme_q.push_back($urandom_range(0, 7) == 0 ? CH_NUL : CH_LF);
        end else if (pick < 93) begin
            // block comment, star heavy so star runs before the close show up
            lexeme_q.push_back(CH_SLASH);
            lexeme_q.push_back(CH_STAR);
            repeat ($urandom_range(0, 10)) begin
                c = ($urandom_range(0, 2) == 0) ? CH_STAR : 8'($urandom_range(1, 255));
                lexeme_q.push_back(c == CH_SLASH ? CH_SPACE : c);
            end
            if ($urandom_range(0, 7) == 0) begin
                lexeme_q.push_back(CH_NUL);
            end else begin
                lexeme_q.push_back(CH_STAR);
                lexeme_q.push_back(CH_SLASH);
            end
        end else if (pick < 96) begin
            lexeme_q.push_back(CH_NUL);
        end else begin
            // noise
            repeat ($urandom_range(1, 3))
                lexeme_q.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
                0:       lexeme_q.push_back(CH_SPACE);
                1:       lexeme_q.push_back(CH_TAB);
                2:       lexeme_q.push_back(CH_CR);
                default: lexeme_q.push_back(CH_LF);
            endcase
        end
    endfunction

    // -----------------------------------------------------------------------
    // request side
    // -----------------------------------------------------------------------
    // optional idle burst, then hold the byte until it is taken
    task automatic feed_byte(input logic [7:0] b, output t_scan_res pred);
        if ($urandom_range(0, 149) == 0)
            in_calm = !in_calm;
        if (!steady_tail && !in_calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_source_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        pred = lex_step(lex_st, b);
    endtask

    task automatic play_rows(input int lo, input int hi);
        t_scan_res pred;
        for (int i = lo; i < hi; i++) begin
            feed_byte(src_rows[i].b, pred);
            queue_events(src_rows[i].typed ? src_rows[i].want : pred);
        end
    endtask

    // -----------------------------------------------------------------------
    // token side: random stall bursts, calm stretches, none in the tail
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            out_calm <= !out_calm;
        if (out_hold != 0 && !steady_tail) begin
            i_out_stall <= 1'b1;
            out_hold    <= out_hold - 1;
        end else if (!steady_tail && !out_calm && $urandom_range(0, 9) == 0) begin
            i_out_stall <= 1'b1;
            out_hold    <= $urandom_range(0, 11);
        end else begin
            i_out_stall <= 1'b0;
            out_hold    <= 0;
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    // compare every taken event with the oldest one owed
    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (token_q.size() == 0) begin
                $display("%0t: stray token event, expected none, got kind %0d char %0h",
                         $time, o_token_kind, o_value_char);
                fail_cnt++;
            end else begin
                want = token_q.pop_front();
                check_field("token_kind", 8'(want.kind), 8'(o_token_kind));
                check_field("value_char", want.ch, o_value_char);
                check_field("has_char", 8'(want.has), 8'(o_has_char));
                check_field("token_first", 8'(want.first), 8'(o_token_first));
                check_field("token_end", 8'(want.tok_end), 8'(o_token_end));
                check_field("run_last", 8'(want.last), 8'(o_run_last));
            end
        end
    end

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    initial begin
        t_scan_res   pred;
        int unsigned sent;
        int          dir_end;
        logic [7:0]  b;
        lex_st      = '0;
        lex_st.mode = M_IDLE;

        // end of an empty source right after reset
        src_rows.push_back(row_fixed(CH_NUL, 2'd1,
                           tk(K_EOF, CH_NUL, 1'b0, 1'b1, 1'b1, 1'b1), NO_EV));
        // string with the extreme content byte, closed by end of source
        src_rows.push_back(row_fixed(CH_QUOTE, 2'd1,
                           tk(K_STR, CH_NUL, 1'b0, 1'b1, 1'b0, 1'b1), NO_EV));
        src_rows.push_back(row_fixed(8'hFF, 2'd1,
                           tk(K_STR, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1), NO_EV));
        src_rows.push_back(row_fixed(CH_NUL, 2'd2,
                           tk(K_STR, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b0),
                           tk(K_EOF, CH_NUL, 1'b0, 1'b1, 1'b1, 1'b1)));
        // keyword closed by a pending equals that becomes an arrow
        for (int i = 0; i < 6; i++)
            src_rows.push_back(row_model(RET_WORD[8 * (5 - i) +: 8]));
        src_rows.push_back(row_model(CH_EQ));
        src_rows.push_back(row_model(CH_GT));
        // integer closed by a slash that opens an empty block comment
        src_rows.push_back(row_model("7"));
        src_rows.push_back(row_model(CH_SLASH));
        src_rows.push_back(row_model(CH_STAR));
        src_rows.push_back(row_model(CH_STAR));
        src_rows.push_back(row_model(CH_SLASH));
        // back-to-back comment, cut off by end of source
        src_rows.push_back(row_model(CH_SLASH));
        src_rows.push_back(row_model(CH_STAR));
        src_rows.push_back(row_model(CH_NUL));
        // lone equals decided by punctuation
        src_rows.push_back(row_model(CH_EQ));
        src_rows.push_back(row_model(";"));
        // line comment to the end of the line
        src_rows.push_back(row_model(CH_SLASH));
        src_rows.push_back(row_model(CH_SLASH));
        src_rows.push_back(row_model(CH_LF));
        // lone divide closed by end of source
        src_rows.push_back(row_model(CH_SLASH));
        src_rows.push_back(row_model(CH_NUL));
        dir_end = src_rows.size();

        // closing rows: end the source, then an unexpected byte halts the block
        src_rows.push_back(row_model(CH_NUL));
        src_rows.push_back(row_fixed(8'hFF, 2'd1,
                           tk(K_ERR, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1), NO_EV));
        src_rows.push_back(row_fixed("a", 2'd0, NO_EV, NO_EV));
        src_rows.push_back(row_fixed(CH_NUL, 2'd0, NO_EV, NO_EV));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        play_rows(0, dir_end);

        sent = 0;
        while (sent < RAND_BYTES) begin
            if (lexeme_q.size() == 0)
                build_lexeme();
            b = lexeme_q.pop_front();
            // keep the block alive until the closing rows
            if (halts_scanner(b))
                b = CH_SPACE;
            feed_byte(b, pred);
            queue_events(pred);
            sent++;
            // halfway: hold off until every owed event is out
            if (sent == RAND_BYTES / 2) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (token_q.size() != 0);
            end
            if (sent == RAND_BYTES - CALM_TAIL)
                steady_tail = 1'b1;
        end

        play_rows(dir_end, src_rows.size());
        i_in_valid <= 1'b0;

        while (token_q.size() != 0)
            @(posedge i_clk);
        // a halted block must stay silent
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("[small_language_tokenizer_top] OK");
        else
            $display("[small_language_tokenizer_top] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("[small_language_tokenizer_top] ERROR");
        $finish;
    end

endmodule
